// ===== hw/rtl/tsnm_pkg.sv =====
`default_nettype none
package tsnm_pkg;

	// Working width of the normalizer datapath and the position of the
	// normalized magnitude.
	localparam int WORD_W     = 64;
	localparam int NORM_BITS  = 30;
	localparam int LEN_W      = 31;
	localparam int LZ_STAGES  = 6;
	localparam int ISQ_STEPS  = 32;

	// Scale input format.
	localparam int SCALE_W    = 16;
	localparam int SCALE_FRAC = 12;

	// Configuration port.
	localparam int EPS_W      = 32;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DISABLE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_DEF    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TANGENT_DEF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BITANGENT_DEF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 3'd4;

	// Pipeline depth of one vector normalizer: abs/max, leading-zero shift,
	// squares, sum, square root, numerator, restoring divide, sign/saturate.
	function automatic int norm_lat(input int frac_bits);
		return 1 + LZ_STAGES + 2 + ISQ_STEPS + 1 + (frac_bits + 1) + 1;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tsnm_norm3.sv =====
`default_nettype none
module tsnm_norm3 #(
	parameter int IN_WIDTH   = 16,
	parameter int COMP_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [2:0][IN_WIDTH-1:0]   vec,
	output logic      [2:0][COMP_WIDTH-1:0] res
);

	localparam int WW  = tsnm_pkg::WORD_W;
	localparam int NB  = tsnm_pkg::NORM_BITS;
	localparam int LW  = tsnm_pkg::LEN_W;
	localparam int LZS = tsnm_pkg::LZ_STAGES;
	localparam int ISQ = tsnm_pkg::ISQ_STEPS;
	localparam int NW  = NB + FRAC_BITS + 1;
	localparam int QB  = FRAC_BITS + 1;
	localparam int SW  = ((QB + 1 > COMP_WIDTH) ? QB + 1 : COMP_WIDTH) + 1;
	localparam int LAT = tsnm_pkg::norm_lat(FRAC_BITS);
	localparam int FLAG_DEPTH = LAT - 1;
	localparam int A_DEPTH    = ISQ + 2;

	localparam logic signed [SW-1:0] CMAX = SW'((1 << (COMP_WIDTH - 1)) - 1);
	localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} flag_t;

	logic [2:0][IN_WIDTH-1:0] mag_c;
	logic [IN_WIDTH-1:0]      max_c;
	flag_t                    fl_c;

	logic [WW-1:0] lzm_s [LZS];
	logic [WW-1:0] lza_s [LZS+1][3];
	flag_t         fl_s  [FLAG_DEPTH];

	logic [NB-1:0]   a30_c [3];
	logic [2*NB-1:0] sq_s  [3];
	logic [NB-1:0]   a_s   [A_DEPTH][3];

	logic [WW-1:0] ix_s [ISQ];
	logic [WW-1:0] ir_s [ISQ+1];
	logic [LW-1:0] len_c;

	logic [NW-1:0] rem_s [QB][3];
	logic [QB-1:0] q_s   [QB+1][3];
	logic [LW-1:0] dl_s  [QB];

	logic signed [SW-1:0] sv_c [3];

	// Magnitudes, signs and the largest magnitude.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fl_c.neg[i] = vec[i][IN_WIDTH-1];
			mag_c[i]    = fl_c.neg[i] ? (~vec[i] + 1'b1) : vec[i];
		end
		max_c = mag_c[0];
		if (mag_c[1] > max_c) begin
			max_c = mag_c[1];
		end
		if (mag_c[2] > max_c) begin
			max_c = mag_c[2];
		end
		fl_c.zero = (max_c == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lzm_s[0] <= WW'(max_c);
			for (int i = 0; i < 3; i++) begin
				lza_s[0][i] <= WW'(mag_c[i]);
			end
			fl_s[0] <= fl_c;
			for (int k = 1; k < FLAG_DEPTH; k++) begin
				fl_s[k] <= fl_s[k-1];
			end
		end
	end

	// Leading-zero shift: all three magnitudes move so the largest has its
	// top bit at the word's top.
	for (genvar j = 0; j < LZS; j++) begin : g_lz
		localparam int SH = (WW / 2) >> j;
		logic hit;
		assign hit = (lzm_s[j][WW-1 -: SH] == '0);
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					lza_s[j+1][i] <= hit ? (lza_s[j][i] << SH) : lza_s[j][i];
				end
			end
		end
		if (j < LZS - 1) begin : g_m
			always_ff @(posedge clk) begin
				if (en) begin
					lzm_s[j+1] <= hit ? (lzm_s[j] << SH) : lzm_s[j];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a30_c[i] = lza_s[LZS][i][WW-1 -: NB];
		end
	end

	// Squares, then their sum.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s[i]   <= a30_c[i] * a30_c[i];
				a_s[0][i] <= a30_c[i];
			end
			ix_s[0] <= WW'(sq_s[0]) + WW'(sq_s[1]) + WW'(sq_s[2]);
			ir_s[0] <= '0;
			for (int k = 1; k < A_DEPTH; k++) begin
				a_s[k] <= a_s[k-1];
			end
		end
	end

	// Integer square root, one result bit per stage.
	for (genvar k = 0; k < ISQ; k++) begin : g_isq
		localparam logic [WW-1:0] BIT = WW'(1) << (WW - 2 - 2 * k);
		logic [WW-1:0] trial;
		logic          take;
		assign trial = ir_s[k] + BIT;
		assign take  = (ix_s[k] >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				ir_s[k+1] <= take ? ((ir_s[k] >> 1) + BIT) : (ir_s[k] >> 1);
			end
		end
		if (k < ISQ - 1) begin : g_x
			always_ff @(posedge clk) begin
				if (en) begin
					ix_s[k+1] <= take ? (ix_s[k] - trial) : ix_s[k];
				end
			end
		end
	end

	assign len_c = ir_s[ISQ][LW-1:0];

	// Numerator with half the divisor added, so the quotient rounds.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= (NW'(a_s[A_DEPTH-1][i]) << FRAC_BITS) + NW'(len_c >> 1);
				q_s[0][i]   <= '0;
			end
			dl_s[0] <= len_c;
		end
	end

	// Restoring divide, one quotient bit per stage.
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int SH = FRAC_BITS - k;
		logic [NW-1:0] dv;
		logic [2:0]    ge;
		assign dv = NW'(dl_s[k]) << SH;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = (rem_s[k][i] >= dv);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					q_s[k+1][i] <= q_s[k][i] | (QB'(ge[i]) << SH);
				end
			end
		end
		if (k < QB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					for (int i = 0; i < 3; i++) begin
						rem_s[k+1][i] <= ge[i] ? (rem_s[k][i] - dv) : rem_s[k][i];
					end
					dl_s[k+1] <= dl_s[k];
				end
			end
		end
	end

	// Restore the sign and clamp to the component range.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sv_c[i] = SW'(q_s[QB][i]);
			if (fl_s[FLAG_DEPTH-1].neg[i]) begin
				sv_c[i] = -sv_c[i];
			end
			if (sv_c[i] > CMAX) begin
				sv_c[i] = CMAX;
			end else if (sv_c[i] < CMIN) begin
				sv_c[i] = CMIN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				res[i] <= fl_s[FLAG_DEPTH-1].zero ? '0 : sv_c[i][COMP_WIDTH-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tangent_space_normal_map_core.sv =====
// Tangent-space normal mapping core.
// Requests arrive on the s_ stream: a texel, a scale and the surface normal,
// tangent and bitangent, each vector as three signed fixed-point components.
// Each request yields exactly one result on the m_ stream: the perturbed,
// normalized normal, or the texel itself while disable mode is set.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, one register
// per write, and should only change while no request is in flight.
// The core is a single stall-able pipeline that accepts one request in every
// cycle while the output is not stalled. Its depth comes from three
// normalizers in series (normal/tangent, bitangent, final sum), each with a
// 32-stage square root and a FRAC_BITS+1 stage divide.
// When m_tready is low while a result waits, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits and loads the register defaults: disable off,
// all three default flags on and an epsilon threshold of one.
`default_nettype none
module tangent_space_normal_map_core #(
	parameter int COMP_WIDTH = 16,
	parameter int FRAC_BITS  = 14,
	localparam int VW  = 3 * COMP_WIDTH,
	localparam int S_W = ((4 * VW + tsnm_pkg::SCALE_W + 7) / 8) * 8,
	localparam int M_W = ((VW + 7) / 8) * 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// color_in, scale, normal_vec, tangent_vec, bitangent_vec, zero pad
	input  wire logic [S_W-1:0]                     s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// normal_out, zero pad
	output logic      [M_W-1:0]                     m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [tsnm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tsnm_pkg::EPS_W-1:0]         cfg_wdata
);

	localparam int CW   = COMP_WIDTH;
	localparam int LN   = tsnm_pkg::norm_lat(FRAC_BITS);
	localparam int SCW  = tsnm_pkg::SCALE_W;
	localparam int TW   = (CW > FRAC_BITS + 2) ? CW : FRAC_BITS + 2;
	localparam int RW   = TW + 2;
	localparam int STW  = SCW + RW;
	localparam int PW   = CW + STW;
	localparam int NPW  = CW + RW;
	localparam int AW   = PW + 2;
	localparam int CXW  = 2 * CW + 1;
	localparam int DW   = (2 * CW > tsnm_pkg::EPS_W) ? 2 * CW : tsnm_pkg::EPS_W;
	localparam int OFS_N = VW + SCW;
	localparam int OFS_T = 2 * VW + SCW;
	localparam int OFS_B = 3 * VW + SCW;
	localparam int VDEPTH = 3 * LN + 4;

	localparam logic signed [TW-1:0] TEX_HALF = TW'(1 << (FRAC_BITS - 1));
	localparam logic signed [TW-1:0] TEX_ONE  = TW'(1 << FRAC_BITS);

	typedef logic [2:0][CW-1:0] vec_t;

	typedef struct packed {
		logic [STW-1:0] st0;
		logic [STW-1:0] st1;
		logic [RW-1:0]  tz;
	} tex_prod_t;

	// Configuration registers.
	logic                       disable_q;
	logic                       nud_q;
	logic                       tud_q;
	logic                       bud_q;
	logic [tsnm_pkg::EPS_W-1:0] eps_q;

	// The whole pipeline advances together; it holds only while a result
	// waits on a stalled receiver.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disable_q <= 1'b0;
			nud_q     <= 1'b1;
			tud_q     <= 1'b1;
			bud_q     <= 1'b1;
			eps_q     <= tsnm_pkg::EPS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				tsnm_pkg::CFG_DISABLE:       disable_q <= cfg_wdata[0];
				tsnm_pkg::CFG_NORMAL_DEF:    nud_q     <= cfg_wdata[0];
				tsnm_pkg::CFG_TANGENT_DEF:   tud_q     <= cfg_wdata[0];
				tsnm_pkg::CFG_BITANGENT_DEF: bud_q     <= cfg_wdata[0];
				tsnm_pkg::CFG_EPSILON:       eps_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage 1: unpack the request.
	logic                  v_s1;
	vec_t                  color_s1;
	logic signed [SCW-1:0] scale_s1;
	vec_t                  nraw_s1;
	vec_t                  traw_s1;
	vec_t                  braw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s1 <= s_tdata[VW-1:0];
			scale_s1 <= s_tdata[VW +: SCW];
			nraw_s1  <= s_tdata[OFS_N +: VW];
			traw_s1  <= s_tdata[OFS_T +: VW];
			braw_s1  <= s_tdata[OFS_B +: VW];
		end
	end

	// Texel path: squared length, near-zero replacement, remap to 2v-1 and
	// the products with the scale.
	logic [2:0][2*CW-1:0]  tsq_s2;
	vec_t                  tex_s2;
	logic signed [SCW-1:0] scale_s2;
	logic [2*CW-1:0]       d_c;
	logic                  rep_c;
	logic signed [TW-1:0]  tsel_c [3];
	logic signed [RW-1:0]  texr_s3 [3];
	logic signed [SCW-1:0] scale_s3;
	tex_prod_t             tp_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tsq_s2[i] <= $signed(color_s1[i]) * $signed(color_s1[i]);
			end
			tex_s2   <= color_s1;
			scale_s2 <= scale_s1;
		end
	end

	always_comb begin
		d_c   = tsq_s2[0] + tsq_s2[1] + tsq_s2[2];
		rep_c = DW'(d_c) < DW'(eps_q);
		for (int i = 0; i < 3; i++) begin
			tsel_c[i] = TW'($signed(tex_s2[i]));
		end
		if (rep_c) begin
			tsel_c[0] = TEX_HALF;
			tsel_c[1] = TEX_HALF;
			tsel_c[2] = TEX_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				texr_s3[i] <= (RW'(tsel_c[i]) <<< 1) - (RW'(1) << FRAC_BITS);
			end
			scale_s3  <= scale_s2;
			tp_s4.st0 <= scale_s3 * texr_s3[0];
			tp_s4.st1 <= scale_s3 * texr_s3[1];
			tp_s4.tz  <= texr_s3[2];
		end
	end

	// Normal and tangent normalizers, with the raw vectors delayed alongside.
	vec_t n_nrm;
	vec_t t_nrm;
	vec_t nraw_dly_q [LN];
	vec_t traw_dly_q [LN];

	tsnm_norm3 #(
		.IN_WIDTH   (CW),
		.COMP_WIDTH (CW),
		.FRAC_BITS  (FRAC_BITS)
	) u_nrm_n (
		.clk (clk),
		.en  (en),
		.vec (nraw_s1),
		.res (n_nrm)
	);

	tsnm_norm3 #(
		.IN_WIDTH   (CW),
		.COMP_WIDTH (CW),
		.FRAC_BITS  (FRAC_BITS)
	) u_nrm_t (
		.clk (clk),
		.en  (en),
		.vec (traw_s1),
		.res (t_nrm)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			nraw_dly_q[0] <= nraw_s1;
			traw_dly_q[0] <= traw_s1;
			for (int k = 1; k < LN; k++) begin
				nraw_dly_q[k] <= nraw_dly_q[k-1];
				traw_dly_q[k] <= traw_dly_q[k-1];
			end
		end
	end

	// Cross product of tangent and normal.
	vec_t                    n_sel;
	vec_t                    t_sel;
	vec_t                    n_x1;
	vec_t                    t_x1;
	logic signed [2*CW-1:0]  pr_x1 [6];
	logic [2:0][CXW-1:0]     c_x2;

	assign n_sel = nud_q ? n_nrm : nraw_dly_q[LN-1];
	assign t_sel = tud_q ? t_nrm : traw_dly_q[LN-1];

	always_ff @(posedge clk) begin
		if (en) begin
			n_x1     <= n_sel;
			t_x1     <= t_sel;
			pr_x1[0] <= $signed(t_sel[1]) * $signed(n_sel[2]);
			pr_x1[1] <= $signed(t_sel[2]) * $signed(n_sel[1]);
			pr_x1[2] <= $signed(t_sel[2]) * $signed(n_sel[0]);
			pr_x1[3] <= $signed(t_sel[0]) * $signed(n_sel[2]);
			pr_x1[4] <= $signed(t_sel[0]) * $signed(n_sel[1]);
			pr_x1[5] <= $signed(t_sel[1]) * $signed(n_sel[0]);
			c_x2[0]  <= CXW'(pr_x1[0]) - CXW'(pr_x1[1]);
			c_x2[1]  <= CXW'(pr_x1[2]) - CXW'(pr_x1[3]);
			c_x2[2]  <= CXW'(pr_x1[4]) - CXW'(pr_x1[5]);
		end
	end

	// Bitangent normalizer and the delay lines that meet it.
	vec_t      b_nrm;
	vec_t      n_dly_q    [LN+1];
	vec_t      t_dly_q    [LN+1];
	vec_t      braw_dly_q [2*LN+2];
	tex_prod_t tp_dly_q   [2*LN-1];

	tsnm_norm3 #(
		.IN_WIDTH   (CXW),
		.COMP_WIDTH (CW),
		.FRAC_BITS  (FRAC_BITS)
	) u_nrm_c (
		.clk (clk),
		.en  (en),
		.vec (c_x2),
		.res (b_nrm)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			n_dly_q[0] <= n_x1;
			t_dly_q[0] <= t_x1;
			for (int k = 1; k < LN + 1; k++) begin
				n_dly_q[k] <= n_dly_q[k-1];
				t_dly_q[k] <= t_dly_q[k-1];
			end
			braw_dly_q[0] <= braw_s1;
			for (int k = 1; k < 2 * LN + 2; k++) begin
				braw_dly_q[k] <= braw_dly_q[k-1];
			end
			tp_dly_q[0] <= tp_s4;
			for (int k = 1; k < 2 * LN - 1; k++) begin
				tp_dly_q[k] <= tp_dly_q[k-1];
			end
		end
	end

	// Weighted sum T*s*x + B*s*y + N*z, the last term aligned to the scale.
	vec_t                 b_sel;
	vec_t                 tn_c;
	vec_t                 nn_c;
	tex_prod_t            tp_c;
	logic signed [PW-1:0]  pt_m1 [3];
	logic signed [PW-1:0]  pb_m1 [3];
	logic signed [NPW-1:0] pn_m1 [3];
	logic [2:0][AW-1:0]    acc_m2;

	assign b_sel = bud_q ? b_nrm : braw_dly_q[2*LN+1];
	assign tn_c  = t_dly_q[LN];
	assign nn_c  = n_dly_q[LN];
	assign tp_c  = tp_dly_q[2*LN-2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pt_m1[i]  <= $signed(tn_c[i]) * $signed(tp_c.st0);
				pb_m1[i]  <= $signed(b_sel[i]) * $signed(tp_c.st1);
				pn_m1[i]  <= $signed(nn_c[i]) * $signed(tp_c.tz);
				acc_m2[i] <= AW'(pt_m1[i]) + AW'(pb_m1[i])
				           + (AW'(pn_m1[i]) <<< tsnm_pkg::SCALE_FRAC);
			end
		end
	end

	// Final normalizer.
	vec_t a_nrm;

	tsnm_norm3 #(
		.IN_WIDTH   (AW),
		.COMP_WIDTH (CW),
		.FRAC_BITS  (FRAC_BITS)
	) u_nrm_a (
		.clk (clk),
		.en  (en),
		.vec (acc_m2),
		.res (a_nrm)
	);

	// Valid bits and the pass-through texel travel the full depth.
	logic [VDEPTH-1:0] vld_dly_q;
	vec_t              color_dly_q [VDEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dly_q <= '0;
		end else if (en) begin
			vld_dly_q <= {vld_dly_q[VDEPTH-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_dly_q[0] <= color_s1;
			for (int k = 1; k < VDEPTH; k++) begin
				color_dly_q[k] <= color_dly_q[k-1];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_dly_q[VDEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= M_W'(disable_q ? color_dly_q[VDEPTH-1] : a_nrm);
		end
	end

	// An accepted request occupies the first stage on the next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted request did not enter the pipeline");

	// A stall freezes every valid bit in flight.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(vld_dly_q))
		else $error("pipeline moved during a stall");

	// A new result is always backed by an item at the pipeline's end.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(vld_dly_q[VDEPTH-1]))
		else $error("result appeared without a request");

endmodule
`default_nettype wire
